@@ rtl/core/assert_macros.svh @@
// Assertion macros for the RTL file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of the given clock while reset is released.
`define ASSERT_CLKD(label, clk_sig, rst_n_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (prop)) \
		else $error(msg);

// Checks a property against the block clock clk and reset arst_n.
`define ASSERT_DEFAULT(label, prop, msg) \
	`ASSERT_CLKD(label, clk, arst_n, prop, msg)

`endif

@@ rtl/core/atcc_pkg.sv @@
package atcc_pkg;

	typedef enum logic [1:0] {
		PS_NORMAL = 2'd0,
		PS_ESC    = 2'd1,
		PS_CSI    = 2'd2
	} parse_state_t;

	typedef enum logic [2:0] {
		K_OTHER     = 3'd0,
		K_NEWLINE   = 3'd1,
		K_RETURN    = 3'd2,
		K_BACKSPACE = 3'd3,
		K_TAB       = 3'd4,
		K_PRINT     = 3'd5
	} byte_kind_t;

	typedef enum logic {
		CMD_DRAW   = 1'b0,
		CMD_SCROLL = 1'b1
	} command_t;

	localparam logic [1:0] REG_ENABLE    = 2'd0;
	localparam logic [1:0] REG_COLUMNS   = 2'd1;
	localparam logic [1:0] REG_TEXT_ROWS = 2'd2;

	localparam logic [7:0] CHAR_ESC      = 8'h1B;
	localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
	localparam logic [7:0] CHAR_M        = 8'h6D;
	localparam logic [7:0] CHAR_ZERO     = 8'h30;
	localparam logic [7:0] CHAR_NINE     = 8'h39;
	localparam logic [7:0] CHAR_NEWLINE  = 8'h0A;
	localparam logic [7:0] CHAR_RETURN   = 8'h0D;
	localparam logic [7:0] CHAR_BACKSP   = 8'h08;
	localparam logic [7:0] CHAR_TAB      = 8'h09;
	localparam logic [7:0] CHAR_SPACE    = 8'h20;
	localparam logic [7:0] CHAR_TILDE    = 8'h7E;

	localparam logic [6:0] GLYPH_SPACE = 7'd32;

	localparam logic [7:0] SGR_RESET = 8'd0;
	localparam logic [7:0] SGR_BASE  = 8'd30;
	localparam logic [7:0] SGR_FIRST = 8'd31;
	localparam logic [7:0] SGR_LAST  = 8'd37;

	localparam logic [23:0] COLOUR_DEFAULT = 24'hE0E0E0;

	localparam logic [23:0] SGR_TABLE [8] = '{
		24'hE0E0E0, 24'hFF4444, 24'h44FF44, 24'hFFFF44,
		24'h6666FF, 24'hFF44FF, 24'h44FFFF, 24'hE0E0E0
	};

	localparam logic [7:0] COLUMNS_RESET   = 8'd80;
	localparam logic [7:0] TEXT_ROWS_RESET = 8'd25;

	typedef struct packed {
		logic       enable;
		logic [7:0] columns;
		logic [7:0] text_rows;
	} cfg_t;

	typedef struct packed {
		byte_kind_t  kind;
		logic [6:0]  glyph;
		logic [23:0] colour;
	} op_t;

	typedef struct packed {
		command_t    command;
		logic [7:0]  column;
		logic [7:0]  text_row;
		logic [6:0]  glyph_code;
		logic [23:0] colour;
		logic        last;
	} result_t;

	function automatic byte_kind_t classify(input logic [7:0] c);
		byte_kind_t k;
		if (c == CHAR_NEWLINE) begin
			k = K_NEWLINE;
		end else if (c == CHAR_RETURN) begin
			k = K_RETURN;
		end else if (c == CHAR_BACKSP) begin
			k = K_BACKSPACE;
		end else if (c == CHAR_TAB) begin
			k = K_TAB;
		end else if (c >= CHAR_SPACE && c <= CHAR_TILDE) begin
			k = K_PRINT;
		end else begin
			k = K_OTHER;
		end
		return k;
	endfunction

endpackage

@@ rtl/core/ansi_text_console_cursor.sv @@
// Text console front end: character bytes arrive one per transfer on the s_ side and
// draw-glyph and scroll-up commands leave on the m_ side. A byte is accepted every cycle
// while the queue of QUEUE_DEPTH entries between the escape parser and the cursor unit
// has room, and the cursor unit retires one queued byte per cycle while its results are
// taken. A byte that both draws and scrolls holds the two-entry output buffer for two
// result transfers, so the next byte is retired no earlier than the second of them.
// Registers enable, columns and text_rows sit at byte addresses 0, 4 and 8; the user
// must write them only while the console is idle, which the block does not enforce.
module ansi_text_console_cursor
	import atcc_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [7:0] column, [15:8] text_row, [22:16] glyph_code,
	                               // [46:23] colour, [47] zero
	output logic        m_tuser,   // [0] command
	output logic        m_tlast
);

`include "assert_macros.svh"

	cfg_t    cfg_q;
	logic    push;
	op_t     push_op;
	logic    q_full;
	logic    pop;
	logic    q_valid;
	op_t     q_op;
	result_t res;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable    <= 1'b0;
			cfg_q.columns   <= COLUMNS_RESET;
			cfg_q.text_rows <= TEXT_ROWS_RESET;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_ENABLE:    cfg_q.enable    <= pwdata[0];
				REG_COLUMNS:   cfg_q.columns   <= pwdata[7:0];
				REG_TEXT_ROWS: cfg_q.text_rows <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_ENABLE:    prdata = {31'd0, cfg_q.enable};
			REG_COLUMNS:   prdata = {24'd0, cfg_q.columns};
			REG_TEXT_ROWS: prdata = {24'd0, cfg_q.text_rows};
			default:       prdata = 32'd0;
		endcase
	end

	atcc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (s_tvalid),
		.in_data  (s_tdata),
		.in_ready (s_tready),
		.q_full   (q_full),
		.push     (push),
		.op       (push_op)
	);

	atcc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.full    (q_full),
		.pop     (pop),
		.valid   (q_valid),
		.pop_op  (q_op)
	);

	atcc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_op      (q_op),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	assign m_tdata = {1'b0, res.colour, res.glyph_code, res.text_row, res.column};
	assign m_tuser = res.command;
	assign m_tlast = res.last;

	`ASSERT_DEFAULT(a_no_push_when_full, !(push && q_full),
		"Parser pushed into a full queue.")
	`ASSERT_DEFAULT(a_first_of_pair_is_draw, (m_tvalid && !m_tlast) |-> (m_tuser == CMD_DRAW),
		"A result that is not the last of its byte must be a draw.")
	`ASSERT_DEFAULT(a_scroll_fields, (m_tvalid && m_tuser == CMD_SCROLL) |->
		(m_tlast && m_tdata == {1'b0, 24'd0, GLYPH_SPACE, 8'd0, 8'd0}),
		"A scroll result must be last and carry fixed fields.")
	`ASSERT_DEFAULT(a_draw_printable, (m_tvalid && m_tuser == CMD_DRAW) |->
		(m_tdata[22:16] >= 7'd32 && m_tdata[22:16] <= 7'd126),
		"A draw result must carry a printable glyph.")

endmodule

@@ rtl/core/atcc_front.sv @@
module atcc_front
	import atcc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       in_valid,
	input  logic [7:0] in_data,
	output logic       in_ready,
	input  logic       q_full,
	output logic       push,
	output op_t        op
);

	parse_state_t state_q, state_d;
	logic [7:0]   sgr_q, sgr_d;
	logic [23:0]  colour_q, colour_d;
	logic         take;
	logic         normal;
	logic         is_digit;
	logic [7:0]   digit;
	logic [11:0]  sgr_mul;
	logic [7:0]   sgr_next;
	logic [7:0]   sgr_off;

	assign in_ready = !q_full;
	assign take     = in_valid && in_ready;
	assign is_digit = in_data >= CHAR_ZERO && in_data <= CHAR_NINE;
	assign digit    = in_data - CHAR_ZERO;
	assign sgr_mul  = ({4'd0, sgr_q} << 3) + ({4'd0, sgr_q} << 1) + {8'd0, digit[3:0]};
	assign sgr_next = (sgr_mul > 12'd255) ? 8'hFF : sgr_mul[7:0];
	assign sgr_off  = sgr_q - SGR_BASE;

	assign op.kind   = classify(in_data);
	assign op.glyph  = in_data[6:0];
	assign op.colour = colour_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= PS_NORMAL;
			sgr_q    <= 8'd0;
			colour_q <= COLOUR_DEFAULT;
		end else begin
			state_q  <= state_d;
			sgr_q    <= sgr_d;
			colour_q <= colour_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		sgr_d    = sgr_q;
		colour_d = colour_q;
		push     = 1'b0;
		normal   = 1'b0;
		if (take && cfg.enable) begin
			case (state_q)
				PS_ESC: begin
					if (in_data == CHAR_LBRACKET) begin
						state_d = PS_CSI;
						sgr_d   = 8'd0;
					end else begin
						state_d = PS_NORMAL;
						normal  = 1'b1;
					end
				end
				PS_CSI: begin
					if (is_digit) begin
						sgr_d = sgr_next;
					end else begin
						state_d = PS_NORMAL;
						if (in_data == CHAR_M) begin
							if (sgr_q == SGR_RESET) begin
								colour_d = COLOUR_DEFAULT;
							end else if (sgr_q >= SGR_FIRST && sgr_q <= SGR_LAST) begin
								colour_d = SGR_TABLE[sgr_off[2:0]];
							end
						end
					end
				end
				default: begin
					normal = 1'b1;
				end
			endcase
			if (normal) begin
				if (in_data == CHAR_ESC) begin
					state_d = PS_ESC;
				end else begin
					state_d = PS_NORMAL;
					push    = 1'b1;
				end
			end
		end
	end

endmodule

@@ rtl/core/atcc_queue.sv @@
module atcc_queue
	import atcc_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	output logic full,
	input  logic pop,
	output logic valid,
	output op_t  pop_op
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	op_t              mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = count_q == CNT_W'(DEPTH);
	assign valid   = count_q != '0;
	assign do_push = push && !full;
	assign do_pop  = pop && valid;
	assign pop_op  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/core/atcc_back.sv @@
module atcc_back
	import atcc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    q_valid,
	input  op_t     q_op,
	output logic    pop,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_res
);

	logic [7:0] cur_col_q, cur_row_q;
	logic [1:0] cnt_q;
	result_t    slot0_q, slot1_q;

	logic       out_take;
	logic [8:0] col_w, row_w;
	logic [7:0] cols_eff, rows_eff;
	logic [7:0] row_final;
	logic       draw, scroll;
	logic [7:0] draw_col;
	logic [6:0] glyph_sel;
	result_t    draw_res, scroll_res, first_res;
	logic [1:0] n_res;

	assign out_valid = cnt_q != 2'd0;
	assign out_res   = slot0_q;
	assign out_take  = out_valid && out_ready;
	assign pop       = q_valid && (cnt_q == 2'd0 || (cnt_q == 2'd1 && out_take));
	assign cols_eff  = (cfg.columns == 8'd0) ? 8'd1 : cfg.columns;
	assign rows_eff  = (cfg.text_rows == 8'd0) ? 8'd1 : cfg.text_rows;

	always_comb begin
		col_w     = {1'b0, cur_col_q};
		row_w     = {1'b0, cur_row_q};
		draw      = 1'b0;
		draw_col  = cur_col_q;
		glyph_sel = GLYPH_SPACE;
		case (q_op.kind)
			K_NEWLINE: begin
				col_w = 9'd0;
				row_w = row_w + 9'd1;
			end
			K_RETURN: begin
				col_w = 9'd0;
			end
			K_BACKSPACE: begin
				if (cur_col_q != 8'd0) begin
					col_w    = col_w - 9'd1;
					draw     = 1'b1;
					draw_col = col_w[7:0];
				end
			end
			K_TAB: begin
				col_w = (col_w + 9'd4) & 9'h1FC;
			end
			K_PRINT: begin
				draw      = 1'b1;
				glyph_sel = q_op.glyph;
				col_w     = col_w + 9'd1;
			end
			default: begin
			end
		endcase
		if (col_w >= {1'b0, cols_eff}) begin
			col_w = 9'd0;
			row_w = row_w + 9'd1;
		end
		scroll    = row_w >= {1'b0, rows_eff};
		row_final = scroll ? (rows_eff - 8'd1) : row_w[7:0];

		draw_res.command    = CMD_DRAW;
		draw_res.column     = draw_col;
		draw_res.text_row   = cur_row_q;
		draw_res.glyph_code = glyph_sel;
		draw_res.colour     = q_op.colour;
		draw_res.last       = !scroll;

		scroll_res.command    = CMD_SCROLL;
		scroll_res.column     = 8'd0;
		scroll_res.text_row   = 8'd0;
		scroll_res.glyph_code = GLYPH_SPACE;
		scroll_res.colour     = 24'd0;
		scroll_res.last       = 1'b1;

		first_res = draw ? draw_res : scroll_res;
		n_res     = {1'b0, draw} + {1'b0, scroll};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q <= 8'd0;
			cur_row_q <= 8'd0;
			cnt_q     <= 2'd0;
		end else begin
			if (pop) begin
				cur_col_q <= col_w[7:0];
				cur_row_q <= row_final;
				cnt_q     <= n_res;
			end else if (out_take) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			slot0_q <= first_res;
			slot1_q <= scroll_res;
		end else if (out_take) begin
			slot0_q <= slot1_q;
		end
	end

endmodule
